// ===== src/dq_pkg.sv =====
package dq_pkg;

	// Operation codes carried in the opcode field of a command beat.
	localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
	localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
	localparam logic [2:0] OP_POP_BACK   = 3'd2;
	localparam logic [2:0] OP_POP_FRONT  = 3'd3;
	localparam logic [2:0] OP_CLEAR      = 3'd4;
	localparam logic [2:0] OP_QUERY      = 3'd5;

	// Status codes reported with every result beat.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL_DROP = 2'd1;
	localparam logic [1:0] ST_POP_EMPTY = 2'd2;

	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [31:0] push_value;
	} dq_cmd_t;

	typedef struct packed {
		logic signed [31:0] front_value;
		logic signed [31:0] back_value;
		logic [8:0]         element_count;
		logic               is_empty;
		logic [1:0]         status;
	} dq_result_t;

endpackage

// ===== src/double_ended_queue.sv =====
// Latency: a push, clear, query or failed operation returns its result beat in the cycle after
// the command beat; a pop that leaves elements behind answers from S_READ, after its memory read.
// Throughput: one command per cycle while busy is low; a pop that leaves elements raises busy
// and takes no new command until the read from the element memory port has returned.
// Reset: head, tail and count return to zero and no result is pending; the element memory
// is not cleared and needs no clearing pass. The receiver cannot stall the result strobe.
module double_ended_queue #(
	parameter int DEPTH = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  dq_pkg::dq_cmd_t     cmd,
	output logic                done,
	output dq_pkg::dq_result_t  result
);
	import dq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	state_t state_q;

	// Queue pointers and cached end values. The front and back elements are
	// kept in registers so that only a pop has to go back to the memory.
	logic [AW-1:0]      head_q, tail_q;
	logic [CW-1:0]      count_q;
	logic signed [31:0] front_q, back_q;
	logic [1:0]         status_q;
	logic               done_q;
	logic               rd_front_q;

	logic               accept;
	logic [AW-1:0]      head_n, tail_n;
	logic [CW-1:0]      count_n;
	logic signed [31:0] front_n, back_n;
	logic [1:0]         status_n;
	logic               we, re, rd_front;
	logic [AW-1:0]      waddr, raddr;
	logic signed [31:0] rdata;
	logic [CW+8:0]      count_ext;

	function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i);
		idx_next = (i == LAST_IDX) ? '0 : i + AW'(1);
	endfunction

	function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] i);
		idx_prev = (i == '0) ? LAST_IDX : i - AW'(1);
	endfunction

	assign accept = start && !busy;
	assign busy   = (state_q == S_READ);

	// Decode one command beat into the next pointer state, the memory write
	// and, for a pop that leaves elements, the read of the new end element.
	always_comb begin
		head_n   = head_q;
		tail_n   = tail_q;
		count_n  = count_q;
		front_n  = front_q;
		back_n   = back_q;
		status_n = ST_OK;
		we       = 1'b0;
		re       = 1'b0;
		rd_front = 1'b0;
		waddr    = tail_q;
		raddr    = head_q;
		case (cmd.opcode)
			OP_PUSH_BACK: begin
				if (count_q == FULL_CNT) begin
					status_n = ST_FULL_DROP;
				end else begin
					we      = 1'b1;
					waddr   = tail_q;
					tail_n  = idx_next(tail_q);
					count_n = count_q + CW'(1);
					back_n  = cmd.push_value;
					if (count_q == '0) begin
						front_n = cmd.push_value;
					end
				end
			end
			OP_PUSH_FRONT: begin
				if (count_q == FULL_CNT) begin
					status_n = ST_FULL_DROP;
				end else begin
					we      = 1'b1;
					head_n  = idx_prev(head_q);
					waddr   = idx_prev(head_q);
					count_n = count_q + CW'(1);
					front_n = cmd.push_value;
					if (count_q == '0) begin
						back_n = cmd.push_value;
					end
				end
			end
			OP_POP_BACK: begin
				if (count_q == '0) begin
					status_n = ST_POP_EMPTY;
				end else begin
					tail_n  = idx_prev(tail_q);
					count_n = count_q - CW'(1);
					if (count_q != CW'(1)) begin
						re    = 1'b1;
						raddr = idx_prev(idx_prev(tail_q));
					end
				end
			end
			OP_POP_FRONT: begin
				if (count_q == '0) begin
					status_n = ST_POP_EMPTY;
				end else begin
					head_n  = idx_next(head_q);
					count_n = count_q - CW'(1);
					if (count_q != CW'(1)) begin
						re       = 1'b1;
						rd_front = 1'b1;
						raddr    = idx_next(head_q);
					end
				end
			end
			OP_CLEAR: begin
				head_n  = '0;
				tail_n  = '0;
				count_n = '0;
			end
			default: begin
			end
		endcase
	end

	// A write and a read never share a cycle, and a read always comes after any
	// earlier write has been registered, so no forwarding path is needed.
	dq_store #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_store (
		.clk    (clk),
		.wr_en  (accept && we),
		.wr_addr(waddr),
		.wr_data(cmd.push_value),
		.rd_en  (accept && re),
		.rd_addr(raddr),
		.rd_data(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			front_q    <= '0;
			back_q     <= '0;
			status_q   <= ST_OK;
			done_q     <= 1'b0;
			rd_front_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					// A beat that needs no memory read answers at the next edge.
					done_q <= accept && !re;
					if (accept) begin
						head_q     <= head_n;
						tail_q     <= tail_n;
						count_q    <= count_n;
						front_q    <= front_n;
						back_q     <= back_n;
						status_q   <= status_n;
						rd_front_q <= rd_front;
						if (re) begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					// The new end element has arrived from the memory.
					if (rd_front_q) begin
						front_q <= rdata;
					end else begin
						back_q <= rdata;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The count may be wider or narrower than the nine-bit result field.
	assign count_ext = (CW + 9)'(count_q);

	assign done                 = done_q;
	assign result.front_value   = (count_q != '0) ? front_q : 32'sd0;
	assign result.back_value    = (count_q != '0) ? back_q : 32'sd0;
	assign result.element_count = count_ext[8:0];
	assign result.is_empty      = (count_q == '0);
	assign result.status        = status_q;

endmodule

// ===== src/dq_store.sv =====
module dq_store #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  logic signed [31:0]   wr_data,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output logic signed [31:0]   rd_data
);

	// Element storage; entries are only read after they have been written.
	logic signed [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== src/dq_checker.sv =====
module dq_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  dq_pkg::dq_cmd_t     cmd,
	input  logic                done,
	input  dq_pkg::dq_result_t  result
);
	import dq_pkg::*;

	// A pending memory read clears busy in the following cycle and ends in a result beat.
	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (done && !busy))
		else $error("busy did not end in a result beat");

	// Every accepted command yields a result beat or a pending read next cycle.
	a_accept_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted command produced no result");

	// An empty queue reports zero ends and a zero count.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.is_empty) |->
		(result.element_count == 9'd0 && result.front_value == 32'sd0 &&
		 result.back_value == 32'sd0))
		else $error("empty queue shows data");

	// A pop on an empty queue leaves it empty.
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_POP_EMPTY) |-> result.is_empty)
		else $error("pop-on-empty status with elements held");

	// Status never carries the unused code.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status == ST_OK || result.status == ST_FULL_DROP ||
		          result.status == ST_POP_EMPTY))
		else $error("unknown status code");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.cmd   (cmd),
	.done  (done),
	.result(result)
);
